FILE: rtl/chs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg: shared constants and codes for the chained hash set
// operation and status codes, key width
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_FIND    = 2'd1;
    localparam logic [1:0] OP_DELETE  = 2'd2;
    localparam logic [1:0] OP_ILLEGAL = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam int KEY_W = 31;

endpackage

FILE: rtl/chained_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set: set of positive keys in a chained hash table
// sequence: the bucket is formed in the divider (load, 31 steps, finish), then
// the head is read and checked, each chain node visited is read and checked,
// and updates are written before the result strobe; key zero skips the divider
// throughput: one request at a time, busy high until the result strobe
// reset: heads cleared by a sweep of all buckets after reset (busy high),
// table_size resets to 1024; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module chained_hash_set #(
    parameter int BUCKETS    = 1024,
    parameter int POOL_NODES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [30:0] key,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [9:0]  bucket
);
    localparam int KW  = chs_pkg::KEY_W;
    localparam int BW  = (BUCKETS > 2) ? $clog2(BUCKETS) : 1;
    localparam int DW  = $clog2(BUCKETS + 1);
    localparam int PW  = $clog2(POOL_NODES + 1);  // link: index + 1, 0 null
    localparam int NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int SW  = $clog2(POOL_NODES + 2);

    // sequencer codes
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_HRD   = 4'd3;
    localparam logic [3:0] S_HCHK  = 4'd4;
    localparam logic [3:0] S_NRD   = 4'd5;
    localparam logic [3:0] S_NCHK  = 4'd6;
    localparam logic [3:0] S_ALLOC = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_PROM  = 4'd10;
    localparam logic [3:0] S_UNL   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]     state_reg, state_next;
    logic [10:0]    size_reg;
    logic [BW-1:0]  clr_reg, clr_next;
    logic [1:0]     op_reg, op_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [PW-1:0]  prev_reg, prev_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [SW-1:0]  steps_reg, steps_next;
    logic [PW-1:0]  free_reg, free_next;
    logic [PW-1:0]  fresh_reg, fresh_next;
    logic [1:0]     st_reg, st_next;
    logic           done_reg, done_next;
    logic [DW-1:0]  eff_size;
    logic           div_go, div_done;
    logic [DW-1:0]  rem;

    // bucket heads and node pool, read data registered
    logic [KW-1:0]  hkey_mem [BUCKETS];
    logic [PW-1:0]  hlink_mem [BUCKETS];
    logic [KW-1:0]  nkey_mem [POOL_NODES];
    logic [PW-1:0]  nlink_mem [POOL_NODES];
    logic [KW-1:0]  hkey_q, nkey_q;
    logic [PW-1:0]  hlink_q, nlink_q;

    logic           h_we, n_we, nl_we;
    logic [BW-1:0]  h_addr;
    logic [KW-1:0]  h_wkey;
    logic [PW-1:0]  h_wlink;
    logic [NW-1:0]  n_raddr, n_waddr;
    logic [KW-1:0]  n_wkey;
    logic [NW-1:0]  nl_waddr;
    logic [PW-1:0]  nl_wlink;

    function automatic logic link_ok(input logic [PW-1:0] l);
        return (l != '0) && ({1'b0, l} <= (PW+1)'(POOL_NODES));
    endfunction

    // clamp configured size into 1..BUCKETS
    always_comb
    begin
        if (size_reg == '0)
            eff_size = DW'(1);
        else if (32'(size_reg) > 32'(BUCKETS))
            eff_size = DW'(BUCKETS);
        else
            eff_size = DW'(size_reg);
    end

    chs_mod_unit #(.DW(DW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (key_reg),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (rem)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = st_reg;
    assign bucket = 10'(b_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        b_next     = b_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        free_next  = free_reg;
        fresh_next = fresh_reg;
        st_next    = st_reg;
        done_next  = 1'b0;
        div_go     = 1'b0;
        h_we       = 1'b0;
        h_addr     = b_reg;
        h_wkey     = '0;
        h_wlink    = '0;
        n_raddr    = NW'(cur_reg - 1'b1);
        n_we       = 1'b0;
        n_waddr    = NW'(fresh_reg);
        n_wkey     = key_reg;
        nl_we      = 1'b0;
        nl_waddr   = NW'(prev_reg - 1'b1);
        nl_wlink   = '0;
        unique case (state_reg)
            S_CLR:
            begin
                h_we   = 1'b1;
                h_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == BUCKETS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    key_next = key;
                    if (key == '0)
                    begin
                        b_next     = '0;
                        st_next    = chs_pkg::ST_INVALID;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // go pulses on entry: dividend register now holds the key
                if (steps_reg == '0)
                begin
                    div_go     = 1'b1;
                    steps_next = SW'(1);
                end
                else if (div_done)
                begin
                    b_next     = BW'(rem);
                    steps_next = '0;
                    if (op_reg == chs_pkg::OP_ILLEGAL)
                    begin
                        st_next    = chs_pkg::ST_INVALID;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_HRD;
                end
            end
            S_HRD:
                state_next = S_HCHK;
            S_HCHK:
            begin
                prev_next  = '0;
                cur_next   = hlink_q;
                steps_next = '0;
                if (hkey_q == '0)
                begin
                    if (op_reg == chs_pkg::OP_INSERT)
                    begin
                        h_we    = 1'b1;
                        h_wkey  = key_reg;
                        h_wlink = hlink_q;
                        st_next = chs_pkg::ST_DONE;
                    end
                    else
                        st_next = chs_pkg::ST_MISS;
                    state_next = S_OUT;
                end
                else if (hkey_q == key_reg)
                begin
                    if (op_reg == chs_pkg::OP_INSERT)
                    begin
                        st_next    = chs_pkg::ST_MISS;
                        state_next = S_OUT;
                    end
                    else if (op_reg == chs_pkg::OP_FIND)
                    begin
                        st_next    = chs_pkg::ST_DONE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = chs_pkg::ST_DONE;
                        if (link_ok(hlink_q))
                            state_next = S_NRD;
                        else
                        begin
                            h_we       = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                end
                else if (link_ok(hlink_q))
                    state_next = S_NRD;
                else if (op_reg == chs_pkg::OP_INSERT)
                    state_next = S_ALLOC;
                else
                begin
                    st_next    = chs_pkg::ST_MISS;
                    state_next = S_OUT;
                end
            end
            S_NRD:
                state_next = S_NCHK;
            S_NCHK:
            begin
                if (op_reg == chs_pkg::OP_DELETE && prev_reg == '0 && hkey_q == key_reg)
                    state_next = S_PROM;
                else if (nkey_q == key_reg)
                begin
                    if (op_reg == chs_pkg::OP_INSERT)
                    begin
                        st_next    = chs_pkg::ST_MISS;
                        state_next = S_OUT;
                    end
                    else if (op_reg == chs_pkg::OP_FIND)
                    begin
                        st_next    = chs_pkg::ST_DONE;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_UNL;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = nlink_q;
                    steps_next = steps_reg + 1'b1;
                    if (link_ok(nlink_q) && 32'(steps_reg) + 1 < POOL_NODES)
                        state_next = S_NRD;
                    else if (op_reg == chs_pkg::OP_INSERT)
                        state_next = S_ALLOC;
                    else
                    begin
                        st_next    = chs_pkg::ST_MISS;
                        state_next = S_OUT;
                    end
                end
            end
            S_ALLOC:
            begin
                if (link_ok(free_reg))
                begin
                    n_raddr    = NW'(free_reg - 1'b1);
                    state_next = S_FRD;
                end
                else if (32'(fresh_reg) < POOL_NODES)
                begin
                    n_we       = 1'b1;
                    n_waddr    = NW'(fresh_reg);
                    nl_we      = 1'b1;
                    nl_waddr   = NW'(fresh_reg);
                    nl_wlink   = '0;
                    cur_next   = fresh_reg + 1'b1;
                    fresh_next = fresh_reg + 1'b1;
                    state_next = S_FCHK;
                end
                else
                begin
                    st_next    = chs_pkg::ST_FULL;
                    state_next = S_OUT;
                end
            end
            S_FRD:
            begin
                // pop free list: nlink_q holds its successor
                free_next  = nlink_q;
                n_we       = 1'b1;
                n_waddr    = NW'(free_reg - 1'b1);
                nl_we      = 1'b1;
                nl_waddr   = NW'(free_reg - 1'b1);
                nl_wlink   = '0;
                cur_next   = free_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                // hook new node after prev or into the head
                if (prev_reg == '0)
                begin
                    h_we    = 1'b1;
                    h_wkey  = hkey_q;
                    h_wlink = cur_reg;
                end
                else
                begin
                    nl_we    = 1'b1;
                    nl_wlink = cur_reg;
                end
                st_next    = chs_pkg::ST_DONE;
                state_next = S_OUT;
            end
            S_PROM:
            begin
                h_we       = 1'b1;
                h_wkey     = nkey_q;
                h_wlink    = nlink_q;
                nl_we      = 1'b1;
                nl_waddr   = NW'(cur_reg - 1'b1);
                nl_wlink   = free_reg;
                free_next  = cur_reg;
                st_next    = chs_pkg::ST_DONE;
                state_next = S_OUT;
            end
            S_UNL:
            begin
                if (prev_reg == '0)
                begin
                    h_we    = 1'b1;
                    h_wkey  = hkey_q;
                    h_wlink = nlink_q;
                    nl_we    = 1'b1;
                    nl_waddr = NW'(cur_reg - 1'b1);
                    nl_wlink = free_reg;
                    free_next  = cur_reg;
                    st_next    = chs_pkg::ST_DONE;
                    state_next = S_OUT;
                end
                else
                begin
                    // relink prev past cur, then free cur next cycle
                    nl_we      = 1'b1;
                    nl_wlink   = nlink_q;
                    prev_next  = '0;
                    state_next = S_PROM;
                    // reuse promote path with head rewrite suppressed below
                end
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                steps_next = '0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // unlink of a middle node: S_PROM must only free, not touch the head
        if (state_reg == S_PROM && op_reg == chs_pkg::OP_DELETE && hkey_q != key_reg)
            h_we = 1'b0;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hkey_mem[h_addr]  <= h_wkey;
            hlink_mem[h_addr] <= h_wlink;
        end
        hkey_q  <= hkey_mem[b_next];
        hlink_q <= hlink_mem[b_next];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
            nkey_mem[n_waddr] <= n_wkey;
        if (nl_we)
            nlink_mem[nl_waddr] <= nl_wlink;
        nkey_q  <= nkey_mem[n_raddr];
        nlink_q <= nlink_mem[n_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            size_reg  <= 11'd1024;
            steps_reg <= '0;
            free_reg  <= '0;
            fresh_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we)
                size_reg <= cfg_data;
            steps_reg <= steps_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        b_reg    <= b_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        st_reg   <= st_next;
    end
endmodule

FILE: rtl/chs_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_mod_unit: iterative remainder
// restoring division, one quotient bit per cycle, remainder only
// ----------------------------------------------------------------------------
module chs_mod_unit #(
    parameter int DW = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [chs_pkg::KEY_W-1:0]   dividend,
    input  logic [DW-1:0]               divisor,
    output logic                        done,
    output logic [DW-1:0]               remainder
);
    localparam int CW = $clog2(chs_pkg::KEY_W + 1);

    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic [chs_pkg::KEY_W-1:0]   sh_reg, sh_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               div_reg, div_next;
    logic [DW:0]                 trial;
    logic [DW:0]                 diff;

    always_comb
    begin
        trial    = {rem_reg, sh_reg[chs_pkg::KEY_W-1]};
        diff     = trial - {1'b0, div_reg};
        run_next = run_reg;
        cnt_next = cnt_reg;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        done     = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = CW'(chs_pkg::KEY_W);
            sh_next  = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
            else
            begin
                // compare and subtract step
                rem_next = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
                sh_next  = {sh_reg[chs_pkg::KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end
endmodule

FILE: tb/sv/chained_hash_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_tb: self-checking bench for the chained hash set
// a class-based set tracker predicts status and bucket for each accepted
// request; directed cases, a chain build and head delete sweep and random
// traffic run under several table sizes, with bursty request timing
// ----------------------------------------------------------------------------
module chained_hash_set_tb;

    localparam int NBUCKETS   = 1024;
    localparam int NPOOL      = 4096;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] bucket;
    } hash_reply_t;

    // golden set model plus the queue of replies still owed by the block
    class set_tracker;
        logic [30:0] head_key [NBUCKETS];
        logic [12:0] head_link [NBUCKETS];
        logic [30:0] node_key [NPOOL];
        logic [12:0] node_link [NPOOL];
        logic [12:0] free_head;
        int          fresh_used;
        logic [10:0] table_size;
        hash_reply_t owed [$];
        int          errors;
        int          replies;
        int          full_seen;

        function new();
            foreach (head_key[i]) head_key[i] = '0;
            foreach (head_link[i]) head_link[i] = '0;
            foreach (node_key[i]) node_key[i] = '0;
            foreach (node_link[i]) node_link[i] = '0;
            free_head  = '0;
            fresh_used = 0;
            table_size = 11'd1024;
            errors     = 0;
            replies    = 0;
            full_seen  = 0;
        endfunction

        function int unsigned hash_of(logic [30:0] k);
            int unsigned modulus;
            modulus = table_size;
            if (modulus < 1) modulus = 1;
            if (modulus > NBUCKETS) modulus = NBUCKETS;
            return k % modulus;
        endfunction

        function logic [12:0] take_node();
            logic [12:0] n;
            if (free_head != 0) begin
                n = free_head;
                free_head = node_link[n - 1];
                return n;
            end
            if (fresh_used < NPOOL) begin
                fresh_used++;
                return 13'(fresh_used);
            end
            return '0;
        endfunction

        function void give_node(logic [12:0] n);
            node_link[n - 1] = free_head;
            free_head = n;
        endfunction

        // chain walk: sets prev (0 = head) and hit node, returns found
        function bit walk(int unsigned b, logic [30:0] k,
                          output logic [12:0] prev, output logic [12:0] hit);
            logic [12:0] p;
            logic [12:0] c;
            p = '0;
            c = head_link[b];
            while (c != 0) begin
                if (node_key[c - 1] == k) begin
                    prev = p;
                    hit  = c;
                    return 1;
                end
                p = c;
                c = node_link[c - 1];
            end
            prev = p;
            hit  = '0;
            return 0;
        endfunction

        function logic [1:0] apply(logic [1:0] op, logic [30:0] k, int unsigned b);
            logic [12:0] prev;
            logic [12:0] hit;
            logic [12:0] n;
            if (k == 0 || op == chs_pkg::OP_ILLEGAL) return chs_pkg::ST_INVALID;
            if (op == chs_pkg::OP_FIND) begin
                if (head_key[b] == 0) return chs_pkg::ST_MISS;
                if (head_key[b] == k) return chs_pkg::ST_DONE;
                return walk(b, k, prev, hit) ? chs_pkg::ST_DONE : chs_pkg::ST_MISS;
            end
            if (op == chs_pkg::OP_INSERT) begin
                if (head_key[b] == 0) begin
                    head_key[b] = k;
                    return chs_pkg::ST_DONE;
                end
                if (head_key[b] == k || walk(b, k, prev, hit)) return chs_pkg::ST_MISS;
                n = take_node();
                if (n == 0) return chs_pkg::ST_FULL;
                node_key[n - 1]  = k;
                node_link[n - 1] = '0;
                if (prev == 0) head_link[b] = n;
                else node_link[prev - 1] = n;
                return chs_pkg::ST_DONE;
            end
            // delete
            if (head_key[b] == 0) return chs_pkg::ST_MISS;
            if (head_key[b] == k) begin
                n = head_link[b];
                if (n != 0) begin
                    head_key[b]  = node_key[n - 1];
                    head_link[b] = node_link[n - 1];
                    give_node(n);
                end else begin
                    head_key[b]  = '0;
                    head_link[b] = '0;
                end
                return chs_pkg::ST_DONE;
            end
            if (!walk(b, k, prev, hit)) return chs_pkg::ST_MISS;
            if (prev == 0) head_link[b] = node_link[hit - 1];
            else node_link[prev - 1] = node_link[hit - 1];
            give_node(hit);
            return chs_pkg::ST_DONE;
        endfunction

        function void note_request(logic [1:0] op, logic [30:0] k);
            hash_reply_t r;
            int unsigned b;
            b = (k == 0) ? 0 : hash_of(k);
            r.status = apply(op, k, b);
            r.bucket = 10'(b);
            if (r.status == chs_pkg::ST_FULL) full_seen++;
            owed.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [9:0] bk);
            hash_reply_t e;
            replies++;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply status=%0d bucket=%0d", $time, st, bk);
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            end
            if (bk !== e.bucket) begin
                errors++;
                $display("%0t: bucket expected %0d actual %0d", $time, e.bucket, bk);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [30:0] key;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  bucket;

    set_tracker  tracker;
    int          cycles;
    int          sent;

    chained_hash_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .key       (key),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .bucket    (bucket)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // replies are accepted on the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done) tracker.check_reply(status, bucket);
    end

    // caller sits at a falling edge; start stays high for back-to-back requests
    task automatic send_request(input logic [1:0] op, input logic [30:0] k);
        start     = 1'b1;
        operation = op;
        key       = k;
        @(posedge clk);
        while (busy) @(posedge clk);
        tracker.note_request(op, k);
        sent++;
        @(negedge clk);
    endtask

    // random gap after a burst, most often none at all
    task automatic maybe_pause();
        if ($urandom_range(0, 7) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // let every owed reply come back with start held low, then stay quiet
    task automatic drain();
        start = 1'b0;
        while (tracker.owed.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_table_size(input logic [10:0] sz);
        drain();
        cfg_we   = 1'b1;
        cfg_data = sz;
        @(negedge clk);
        cfg_we   = 1'b0;
        tracker.table_size = sz;
    endtask

    task automatic random_phase(input int count, input int unsigned key_span);
        logic [1:0]  op;
        logic [30:0] k;
        int          burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       op = chs_pkg::OP_ILLEGAL;
                1,2,3,4,5,6,7,8: op = chs_pkg::OP_INSERT;
                9,10,11,12,13:   op = chs_pkg::OP_FIND;
                default: op = chs_pkg::OP_DELETE;
            endcase
            case ($urandom_range(0, 15))
                0:       k = '0;
                1, 2:    k = 31'($urandom);
                default: k = 31'($urandom_range(1, key_span));
            endcase
            send_request(op, k);
            if (burst == 0) begin
                maybe_pause();
                burst = $urandom_range(1, 20);
            end
            burst--;
        end
    endtask

    initial
    begin
        tracker   = new();
        cycles    = 0;
        sent      = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = chs_pkg::OP_INSERT;
        key       = '0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, invalid requests, chain edits in one bucket
        send_request(chs_pkg::OP_INSERT,  31'h7fffffff);
        send_request(chs_pkg::OP_FIND,    31'h7fffffff);
        send_request(chs_pkg::OP_INSERT,  31'h7fffffff);
        send_request(chs_pkg::OP_DELETE,  31'h7fffffff);
        send_request(chs_pkg::OP_FIND,    31'h7fffffff);
        send_request(chs_pkg::OP_DELETE,  31'd5);
        send_request(chs_pkg::OP_INSERT,  31'd0);
        send_request(chs_pkg::OP_FIND,    31'd0);
        send_request(chs_pkg::OP_DELETE,  31'd0);
        send_request(chs_pkg::OP_ILLEGAL, 31'd1234);
        send_request(chs_pkg::OP_ILLEGAL, 31'd0);
        set_table_size(11'd7);
        send_request(chs_pkg::OP_INSERT,  31'd3);
        send_request(chs_pkg::OP_INSERT,  31'd10);
        send_request(chs_pkg::OP_INSERT,  31'd17);
        send_request(chs_pkg::OP_INSERT,  31'd24);
        send_request(chs_pkg::OP_FIND,    31'd24);
        send_request(chs_pkg::OP_DELETE,  31'd17);   // middle of the chain
        send_request(chs_pkg::OP_DELETE,  31'd3);    // head with a chain behind it
        send_request(chs_pkg::OP_FIND,    31'd10);
        send_request(chs_pkg::OP_DELETE,  31'd10);
        send_request(chs_pkg::OP_DELETE,  31'd24);   // head alone
        send_request(chs_pkg::OP_FIND,    31'd31);
        set_table_size(11'd0);                       // acts as one bucket
        send_request(chs_pkg::OP_INSERT,  31'd99);
        send_request(chs_pkg::OP_DELETE,  31'd99);

        // size changes with keys left in place
        set_table_size(11'd1);
        random_phase(130, 60);
        set_table_size(11'd2047);          // clamps to the full table
        random_phase(130, 3000);
        drain();                           // sender holds off until all replies are in
        set_table_size(11'd13);
        random_phase(130, 120);

        // short chains under the first heads, then head deletes refill the free list
        set_table_size(11'd1024);
        for (int j = 1; j <= 3; j++) begin
            for (int b = 0; b < 48; b++) begin
                send_request(chs_pkg::OP_INSERT, 31'(b + NBUCKETS * (j + 8)));
                maybe_pause();
            end
        end
        send_request(chs_pkg::OP_INSERT, 31'(NBUCKETS * 20 + 7));
        send_request(chs_pkg::OP_INSERT, 31'(NBUCKETS * 21 + 40));
        for (int b = 0; b < 48; b++) begin
            send_request(chs_pkg::OP_DELETE, 31'(b + NBUCKETS * 9));
            maybe_pause();
        end
        send_request(chs_pkg::OP_INSERT, 31'(NBUCKETS * 22 + 7));

        set_table_size(11'd1500);
        random_phase(150, 4000);
        set_table_size(11'd2);
        random_phase(120, 80);
        set_table_size(11'd97);
        random_phase(150, 400);

        drain();
        repeat (50) @(negedge clk);
        $display("%0d requests sent, %0d replies checked, %0d pool-full replies",
                 sent, tracker.replies, tracker.full_seen);
        $display("table sizes 0 to 2047 incl. clamped ones; chain edits and free-list reuse");
        if (tracker.errors == 0 && tracker.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/chs_pkg.sv
rtl/chs_mod_unit.sv
rtl/chained_hash_set.sv
tb/sv/chained_hash_set_tb.sv
